>>> hw/rtl/mtep_pkg.sv
// ---------------------------------------------------------------------------
// mtep_pkg: shared types and constants
// Byte classes, queue entry and result word of the track event parser.
// ---------------------------------------------------------------------------
package mtep_pkg;

  localparam int unsigned MAX_VLQ_BYTES = 4;
  localparam int unsigned VLQ_CNT_W     = 3;
  localparam int unsigned TICK_W        = 28;
  localparam int unsigned TEMPO_W       = 24;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] META_TEMPO   = 8'h51;

  localparam logic [1:0] KIND_SHORT   = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_EOT     = 2'd3;

  // classified byte as it travels through the queue
  typedef struct packed {
    logic       track_start;
    logic [7:0] data;
    logic       is_status;   // bit 7 set
    logic       is_channel;  // 80..EF
    logic       is_sysex;    // F0 or F7
    logic       is_meta;     // FF
    logic       is_eot;      // meta type end of track
    logic       is_tempo;    // meta type set tempo
  } item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [TICK_W-1:0]  delta_ticks;
    logic [7:0]         status;
    logic [7:0]         data1;
    logic [7:0]         data2;
    logic [TICK_W-1:0]  payload_length;
    logic               last_payload;
    logic               tempo_valid;
    logic [TEMPO_W-1:0] tempo_us;
  } result_t;

  function automatic logic is_two_data(input logic [7:0] st);
    logic [3:0] hi;
    hi = st[7:4];
    return (hi == 4'h8) || (hi == 4'h9) || (hi == 4'hA) || (hi == 4'hB) || (hi == 4'hE);
  endfunction

endpackage

>>> hw/rtl/mtep_front.sv
// ---------------------------------------------------------------------------
// mtep_front: input side
// Accepts raw bytes while the queue has room and tags each with its class.
// ---------------------------------------------------------------------------
module mtep_front (
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           track_start,
  input  logic [7:0]     byte_in,
  input  logic           queue_full,
  output logic           push,
  output mtep_pkg::item_t push_item
);

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_item.track_start = track_start;
    push_item.data        = byte_in;
    push_item.is_status   = byte_in[7];
    push_item.is_channel  = byte_in[7] && (byte_in[7:4] != 4'hF);
    push_item.is_sysex    = (byte_in == mtep_pkg::ST_SYSEX) ||
                            (byte_in == mtep_pkg::ST_SYSEX_ESC);
    push_item.is_meta     = (byte_in == mtep_pkg::ST_META);
    push_item.is_eot      = (byte_in == mtep_pkg::META_EOT);
    push_item.is_tempo    = (byte_in == mtep_pkg::META_TEMPO);
  end

endmodule

>>> hw/rtl/mtep_queue.sv
// ---------------------------------------------------------------------------
// mtep_queue: classified byte queue
// Small FIFO that decouples the input side from the event machine.
// ---------------------------------------------------------------------------
module mtep_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mtep_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output mtep_pkg::item_t head
);

  mtep_pkg::item_t entries [mtep_pkg::QUEUE_DEPTH];
  logic [mtep_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [mtep_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [mtep_pkg::QUEUE_CNT_W-1:0] count;

  assign full      = (count == mtep_pkg::QUEUE_CNT_W'(mtep_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/mtep_back.sv
// ---------------------------------------------------------------------------
// mtep_back: event machine
// Walks delta time, status, data, meta type, length and payload phases one
// byte per cycle unless stalled; the result sits in an output register.
// ---------------------------------------------------------------------------
module mtep_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  mtep_pkg::item_t item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output mtep_pkg::result_t result
);

  localparam logic [2:0] PH_DELTA     = 3'd0;
  localparam logic [2:0] PH_STATUS    = 3'd1;
  localparam logic [2:0] PH_DATA1     = 3'd2;
  localparam logic [2:0] PH_DATA2     = 3'd3;
  localparam logic [2:0] PH_META_TYPE = 3'd4;
  localparam logic [2:0] PH_LENGTH    = 3'd5;
  localparam logic [2:0] PH_PAYLOAD   = 3'd6;
  localparam logic [2:0] PH_STOPPED   = 3'd7;

  localparam int unsigned TW = mtep_pkg::TICK_W;
  localparam int unsigned EW = mtep_pkg::TEMPO_W;
  localparam int unsigned CW = mtep_pkg::VLQ_CNT_W;

  logic [2:0]    phase,          phase_next;
  logic [7:0]    running_status, running_status_next;
  logic [7:0]    current_status, current_status_next;
  logic [TW-1:0] vlq_acc,        vlq_acc_next;
  logic [CW-1:0] vlq_cnt,        vlq_cnt_next;
  logic [TW-1:0] held_delta,     held_delta_next;
  logic [7:0]    held_data1,     held_data1_next;
  logic          held_eot,       held_eot_next;
  logic          held_tempo,     held_tempo_next;
  logic [TW-1:0] payload_rem,    payload_rem_next;
  logic [1:0]    payload_idx,    payload_idx_next;
  logic [EW-1:0] tempo_acc,      tempo_acc_next;

  // state as seen after an optional track start clear
  logic [2:0]    e_phase;
  logic [7:0]    e_running, e_current, e_hd1;
  logic [TW-1:0] e_acc, e_hdelta, e_rem;
  logic [CW-1:0] e_cnt;
  logic [1:0]    e_idx;
  logic [EW-1:0] e_tacc;
  logic          e_eot, e_tempo;

  logic [7:0]    b;
  logic [TW-1:0] vlq_val;
  logic [CW-1:0] vlq_cnt_inc;
  logic          vlq_done;
  logic          is_meta_cur;
  logic [TW-1:0] rem_dec;
  logic [1:0]    idx_inc;
  logic [EW-1:0] tacc_shift;

  logic              res_valid;
  mtep_pkg::result_t res;

  assign pop = item_valid && (!out_valid || !out_stall);
  assign b   = item.data;

  always_comb begin
    e_phase   = item.track_start ? PH_DELTA : phase;
    e_running = item.track_start ? '0 : running_status;
    e_current = item.track_start ? '0 : current_status;
    e_acc     = item.track_start ? '0 : vlq_acc;
    e_cnt     = item.track_start ? '0 : vlq_cnt;
    e_hdelta  = item.track_start ? '0 : held_delta;
    e_hd1     = item.track_start ? '0 : held_data1;
    e_eot     = item.track_start ? 1'b0 : held_eot;
    e_tempo   = item.track_start ? 1'b0 : held_tempo;
    e_rem     = item.track_start ? '0 : payload_rem;
    e_idx     = item.track_start ? '0 : payload_idx;
    e_tacc    = item.track_start ? '0 : tempo_acc;

    // variable-length quantity step
    vlq_val     = {((e_cnt == '0) ? {(TW-7){1'b0}} : e_acc[TW-8:0]), b[6:0]};
    vlq_cnt_inc = e_cnt + 1'b1;
    vlq_done    = !b[7] || (vlq_cnt_inc >= CW'(mtep_pkg::MAX_VLQ_BYTES));

    is_meta_cur = (e_current == mtep_pkg::ST_META);
    rem_dec     = e_rem - 1'b1;
    idx_inc     = e_idx + 1'b1;
    tacc_shift  = {e_tacc[EW-9:0], b};

    phase_next          = e_phase;
    running_status_next = e_running;
    current_status_next = e_current;
    vlq_acc_next        = e_acc;
    vlq_cnt_next        = e_cnt;
    held_delta_next     = e_hdelta;
    held_data1_next     = e_hd1;
    held_eot_next       = e_eot;
    held_tempo_next     = e_tempo;
    payload_rem_next    = e_rem;
    payload_idx_next    = e_idx;
    tempo_acc_next      = e_tacc;

    res_valid          = 1'b0;
    res.kind           = mtep_pkg::KIND_SHORT;
    res.delta_ticks    = e_hdelta;
    res.status         = e_current;
    res.data1          = b;
    res.data2          = '0;
    res.payload_length = '0;
    res.last_payload   = 1'b0;
    res.tempo_valid    = 1'b0;
    res.tempo_us       = '0;

    unique case (e_phase)
      PH_DELTA: begin
        vlq_acc_next = vlq_val;
        if (vlq_done) begin
          vlq_cnt_next    = '0;
          held_delta_next = vlq_val;
          phase_next      = PH_STATUS;
        end else begin
          vlq_cnt_next = vlq_cnt_inc;
        end
      end

      PH_STATUS: begin
        if (item.is_status) begin
          current_status_next = b;
          if (item.is_channel) begin
            running_status_next = b;
          end
          if (item.is_sysex) begin
            held_data1_next = '0;
            held_eot_next   = 1'b0;
            held_tempo_next = 1'b0;
            phase_next      = PH_LENGTH;
          end else if (item.is_meta) begin
            phase_next = PH_META_TYPE;
          end else begin
            phase_next = PH_DATA1;
          end
        end else begin
          current_status_next = e_running;
          res.status          = e_running;
          if ((e_running != '0) && mtep_pkg::is_two_data(e_running)) begin
            held_data1_next = b;
            phase_next      = PH_DATA2;
          end else begin
            res_valid  = 1'b1;
            phase_next = PH_DELTA;
          end
        end
      end

      PH_DATA1: begin
        if (mtep_pkg::is_two_data(e_current)) begin
          held_data1_next = b;
          phase_next      = PH_DATA2;
        end else begin
          res_valid  = 1'b1;
          phase_next = PH_DELTA;
        end
      end

      PH_DATA2: begin
        res_valid  = 1'b1;
        res.data1  = e_hd1;
        res.data2  = b;
        phase_next = PH_DELTA;
      end

      PH_META_TYPE: begin
        held_data1_next = b;
        held_eot_next   = item.is_eot;
        held_tempo_next = item.is_tempo;
        phase_next      = PH_LENGTH;
      end

      PH_LENGTH: begin
        vlq_acc_next = vlq_val;
        if (vlq_done) begin
          vlq_cnt_next       = '0;
          payload_rem_next   = vlq_val;
          payload_idx_next   = '0;
          tempo_acc_next     = '0;
          res_valid          = 1'b1;
          res.kind           = (is_meta_cur && e_eot) ? mtep_pkg::KIND_EOT
                                                      : mtep_pkg::KIND_HEADER;
          res.data1          = e_hd1;
          res.payload_length = vlq_val;
          if (vlq_val != '0) begin
            phase_next = PH_PAYLOAD;
          end else begin
            phase_next = (is_meta_cur && e_eot) ? PH_STOPPED : PH_DELTA;
          end
        end else begin
          vlq_cnt_next = vlq_cnt_inc;
        end
      end

      PH_PAYLOAD: begin
        if (is_meta_cur && e_tempo && (e_idx != 2'd3)) begin
          tempo_acc_next   = tacc_shift;
          payload_idx_next = idx_inc;
          if (idx_inc == 2'd3) begin
            res.tempo_valid = 1'b1;
            res.tempo_us    = tacc_shift;
          end
        end
        payload_rem_next   = rem_dec;
        res_valid          = 1'b1;
        res.kind           = mtep_pkg::KIND_PAYLOAD;
        res.payload_length = e_acc;
        res.last_payload   = (rem_dec == '0);
        if (rem_dec == '0) begin
          phase_next = (is_meta_cur && e_eot) ? PH_STOPPED : PH_DELTA;
        end
      end

      PH_STOPPED: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DELTA;
      running_status <= '0;
      current_status <= '0;
      vlq_acc        <= '0;
      vlq_cnt        <= '0;
      held_delta     <= '0;
      held_data1     <= '0;
      held_eot       <= 1'b0;
      held_tempo     <= 1'b0;
      payload_rem    <= '0;
      payload_idx    <= '0;
      tempo_acc      <= '0;
    end else if (pop) begin
      phase          <= phase_next;
      running_status <= running_status_next;
      current_status <= current_status_next;
      vlq_acc        <= vlq_acc_next;
      vlq_cnt        <= vlq_cnt_next;
      held_delta     <= held_delta_next;
      held_data1     <= held_data1_next;
      held_eot       <= held_eot_next;
      held_tempo     <= held_tempo_next;
      payload_rem    <= payload_rem_next;
      payload_idx    <= payload_idx_next;
      tempo_acc      <= tempo_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      result <= res;
    end
  end

endmodule

>>> hw/rtl/midi_track_event_parser.sv
// ---------------------------------------------------------------------------
// midi_track_event_parser: standard MIDI file track event parser
// Byte-wide track chunk decoder with a classifying front, a byte queue and
// an event machine that emits short, header, end of track and payload words.
// ---------------------------------------------------------------------------
// Path: each taken byte is written into the queue; the event machine pops it
//   and loads its result into the output register once that register is free.
// Throughput: one byte per cycle unless the queue is full; the event machine
//   retires a queued byte each cycle that its output register can be loaded.
// Reset: rst (synchronous) empties the queue, clears the output valid and
//   puts the machine back to expecting a delta time; track_start does the
//   same to the parse state in-line, ahead of its own byte.
module midi_track_event_parser (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        track_start,
  input  logic [7:0]  byte_in,
  // event output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [27:0] delta_ticks,
  output logic [7:0]  status,
  output logic [7:0]  data1,
  output logic [7:0]  data2,
  output logic [27:0] payload_length,
  output logic        last_payload,
  output logic        tempo_valid,
  output logic [23:0] tempo_us
);

  logic              push;
  mtep_pkg::item_t   push_item;
  logic              queue_full;
  logic              queue_valid;
  logic              pop;
  mtep_pkg::item_t   head;
  mtep_pkg::result_t result;

  // front: tag each byte (status, channel, sysex, meta, meta type)
  mtep_front u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .track_start (track_start),
    .byte_in     (byte_in),
    .queue_full  (queue_full),
    .push        (push),
    .push_item   (push_item)
  );

  // queue: lets input keep flowing while the output side is stalled
  mtep_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_valid),
    .head      (head)
  );

  // back: phase machine plus registered result
  mtep_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (queue_valid),
    .item       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign kind           = result.kind;
  assign delta_ticks    = result.delta_ticks;
  assign status         = result.status;
  assign data1          = result.data1;
  assign data2          = result.data2;
  assign payload_length = result.payload_length;
  assign last_payload   = result.last_payload;
  assign tempo_valid    = result.tempo_valid;
  assign tempo_us       = result.tempo_us;

endmodule

>>> tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench: MIDI track event parser check
// Feeds track chunk bytes through the valid/stall input and compares every
// event word on the output with a cycle-free model of the parser. A short
// table of hand-picked bytes comes first, then randomly built tracks made
// of channel, system, sysex and meta events with some broken sequences.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TARGET_BYTES = 1900;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned QUIET_LO     = 800;   // no idling on either side
  localparam int unsigned QUIET_HI     = 1200;  // between these byte indexes
  localparam int unsigned DRAIN_CYCLES = 20;    // queue depth plus latency, padded

  // parse phases of the model
  typedef enum logic [3:0] {
    WAIT_DELTA, WAIT_STATUS, WAIT_DATA1, WAIT_DATA2,
    WAIT_META_TYPE, WAIT_LENGTH, IN_PAYLOAD, STOPPED
  } parse_phase_t;

  // one byte to send; fixed_ev marks a table row whose event word is typed in
  typedef struct packed {
    bit                ts;
    logic [7:0]        data;
    bit                fixed_ev;
    mtep_pkg::result_t ev;
  } track_byte_t;

  localparam mtep_pkg::result_t NIL = '0;

  // Directed rows: data byte with no running status, longest delta time
  // (fourth byte still has bit 7 set), running status, empty sysex, tempo
  // meta, end of track, and a byte that must be ignored after it.
  localparam track_byte_t DIRECTED [27] = '{
    '{1'b1, 8'h00, 1'b0, NIL},
    '{1'b0, 8'h45, 1'b1,
      '{mtep_pkg::KIND_SHORT, 28'd0, 8'h00, 8'h45, 8'h00, 28'd0, 1'b0, 1'b0, 24'd0}},
    '{1'b0, 8'hFF, 1'b0, NIL},
    '{1'b0, 8'hFF, 1'b0, NIL},
    '{1'b0, 8'hFF, 1'b0, NIL},
    '{1'b0, 8'hFF, 1'b0, NIL},
    '{1'b0, 8'h90, 1'b0, NIL},
    '{1'b0, 8'h3C, 1'b0, NIL},
    '{1'b0, 8'h7F, 1'b1,
      '{mtep_pkg::KIND_SHORT, 28'hFFFFFFF, 8'h90, 8'h3C, 8'h7F, 28'd0, 1'b0, 1'b0,
        24'd0}},
    '{1'b0, 8'h00, 1'b0, NIL},
    '{1'b0, 8'h40, 1'b0, NIL},
    '{1'b0, 8'h00, 1'b0, NIL},
    '{1'b0, 8'h00, 1'b0, NIL},
    '{1'b0, 8'hF0, 1'b0, NIL},
    '{1'b0, 8'h00, 1'b1,
      '{mtep_pkg::KIND_HEADER, 28'd0, 8'hF0, 8'h00, 8'h00, 28'd0, 1'b0, 1'b0, 24'd0}},
    '{1'b0, 8'h00, 1'b0, NIL},
    '{1'b0, 8'hFF, 1'b0, NIL},
    '{1'b0, 8'h51, 1'b0, NIL},
    '{1'b0, 8'h03, 1'b0, NIL},
    '{1'b0, 8'h07, 1'b0, NIL},
    '{1'b0, 8'hA1, 1'b0, NIL},
    '{1'b0, 8'h20, 1'b0, NIL},
    '{1'b0, 8'h00, 1'b0, NIL},
    '{1'b0, 8'hFF, 1'b0, NIL},
    '{1'b0, 8'h2F, 1'b0, NIL},
    '{1'b0, 8'h00, 1'b1,
      '{mtep_pkg::KIND_EOT, 28'd0, 8'hFF, 8'h2F, 8'h00, 28'd0, 1'b0, 1'b0, 24'd0}},
    '{1'b0, 8'h90, 1'b0, NIL}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        track_start = 1'b0;
  logic [7:0]  byte_in = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [27:0] delta_ticks;
  logic [7:0]  status;
  logic [7:0]  data1;
  logic [7:0]  data2;
  logic [27:0] payload_length;
  logic        last_payload;
  logic        tempo_valid;
  logic [23:0] tempo_us;

  midi_track_event_parser u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .track_start    (track_start),
    .byte_in        (byte_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .delta_ticks    (delta_ticks),
    .status         (status),
    .data1          (data1),
    .data2          (data2),
    .payload_length (payload_length),
    .last_payload   (last_payload),
    .tempo_valid    (tempo_valid),
    .tempo_us       (tempo_us)
  );

  always #5 clk = ~clk;

  // Bookkeeping shared by the processes below.
  track_byte_t        track_bytes[$];     // everything the sender will push
  mtep_pkg::result_t  pending_events[$];  // event words still owed by the block
  int unsigned        n_errors = 0;
  int unsigned        cycles = 0;
  bit                 quiet = 1'b0;       // long stretch with no idling at all

  // -------------------------------------------------------------------------
  // Parser model state
  // -------------------------------------------------------------------------
  parse_phase_t phase;
  logic [7:0]   run_st;     // last channel status, for running status
  logic [7:0]   cur_st;     // status of the event being parsed
  logic [27:0]  vlq_acc;
  logic [2:0]   vlq_cnt;
  logic [27:0]  ev_delta;
  logic [7:0]   ev_d1;      // first data byte, or meta type
  logic [27:0]  pay_left;
  logic [1:0]   pay_idx;    // tempo bytes seen so far
  logic [23:0]  tempo_acc;

  function automatic void clear_parser();
    phase     = WAIT_DELTA;
    run_st    = '0;
    cur_st    = '0;
    vlq_acc   = '0;
    vlq_cnt   = '0;
    ev_delta  = '0;
    ev_d1     = '0;
    pay_left  = '0;
    pay_idx   = '0;
    tempo_acc = '0;
  endfunction

  // Note off/on, poly pressure, control change and pitch bend carry two
  // data bytes; program change and channel pressure carry one.
  function automatic bit has_two_data(input logic [7:0] st);
    case (st[7:4])
      4'h8, 4'h9, 4'hA, 4'hB, 4'hE: return 1'b1;
      default:                      return 1'b0;
    endcase
  endfunction

  // Variable-length quantity: ends on a byte with bit 7 clear, or on the
  // last allowed byte whatever its bit 7.
  function automatic bit vlq_step(input logic [7:0] b);
    if (vlq_cnt == 0) vlq_acc = '0;
    vlq_acc = {vlq_acc[20:0], b[6:0]};
    vlq_cnt = vlq_cnt + 3'd1;
    if (!b[7] || vlq_cnt >= mtep_pkg::MAX_VLQ_BYTES) begin
      vlq_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic mtep_pkg::result_t event_word(input logic [1:0] k,
                                                   input logic [7:0] d1,
                                                   input logic [7:0] d2,
                                                   input logic [27:0] len,
                                                   input logic lst, input logic tv,
                                                   input logic [23:0] tempo);
    mtep_pkg::result_t w;
    w.kind           = k;
    w.delta_ticks    = ev_delta;
    w.status         = cur_st;
    w.data1          = d1;
    w.data2          = d2;
    w.payload_length = len;
    w.last_payload   = lst;
    w.tempo_valid    = tv;
    w.tempo_us       = tempo;
    return w;
  endfunction

  // Advances the model by one byte; returns 1 when the byte yields an event.
  function automatic bit parse_byte(input bit ts, input logic [7:0] b,
                                    output mtep_pkg::result_t ev);
    bit          is_eot;
    bit          is_tempo;
    bit          lst;
    bit          tv;
    logic [23:0] tempo;
    ev = '0;
    if (ts) clear_parser();
    is_eot   = (cur_st == mtep_pkg::ST_META) && (ev_d1 == mtep_pkg::META_EOT);
    is_tempo = (cur_st == mtep_pkg::ST_META) && (ev_d1 == mtep_pkg::META_TEMPO);
    case (phase)
      WAIT_DELTA: begin
        if (vlq_step(b)) begin
          ev_delta = vlq_acc;
          phase    = WAIT_STATUS;
        end
        return 1'b0;
      end
      WAIT_STATUS: begin
        if (b[7]) begin
          cur_st = b;
          if (b < mtep_pkg::ST_SYSEX) run_st = b;   // only channel statuses are kept
          if (b == mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_SYSEX_ESC) begin
            ev_d1 = '0;
            phase = WAIT_LENGTH;
          end else if (b == mtep_pkg::ST_META) begin
            phase = WAIT_META_TYPE;
          end else begin
            phase = WAIT_DATA1;
          end
          return 1'b0;
        end
        // data byte in status position: running status, or status 0 if none
        cur_st = run_st;
        if (cur_st != 0 && has_two_data(cur_st)) begin
          ev_d1 = b;
          phase = WAIT_DATA2;
          return 1'b0;
        end
        ev    = event_word(mtep_pkg::KIND_SHORT, b, '0, '0, 1'b0, 1'b0, '0);
        phase = WAIT_DELTA;
        return 1'b1;
      end
      WAIT_DATA1: begin
        if (has_two_data(cur_st)) begin
          ev_d1 = b;
          phase = WAIT_DATA2;
          return 1'b0;
        end
        ev    = event_word(mtep_pkg::KIND_SHORT, b, '0, '0, 1'b0, 1'b0, '0);
        phase = WAIT_DELTA;
        return 1'b1;
      end
      WAIT_DATA2: begin
        ev    = event_word(mtep_pkg::KIND_SHORT, ev_d1, b, '0, 1'b0, 1'b0, '0);
        phase = WAIT_DELTA;
        return 1'b1;
      end
      WAIT_META_TYPE: begin
        ev_d1 = b;
        phase = WAIT_LENGTH;
        return 1'b0;
      end
      WAIT_LENGTH: begin
        if (!vlq_step(b)) return 1'b0;
        pay_left  = vlq_acc;
        pay_idx   = '0;
        tempo_acc = '0;
        ev = event_word(is_eot ? mtep_pkg::KIND_EOT : mtep_pkg::KIND_HEADER,
                        ev_d1, '0, vlq_acc, 1'b0, 1'b0, '0);
        if (pay_left != 0) phase = IN_PAYLOAD;
        else               phase = is_eot ? STOPPED : WAIT_DELTA;
        return 1'b1;
      end
      IN_PAYLOAD: begin
        tv    = 1'b0;
        tempo = '0;
        // tempo is the first three payload bytes, big endian
        if (is_tempo && pay_idx < 3) begin
          tempo_acc = {tempo_acc[15:0], b};
          pay_idx   = pay_idx + 2'd1;
          if (pay_idx == 3) begin
            tv    = 1'b1;
            tempo = tempo_acc;
          end
        end
        pay_left = pay_left - 28'd1;
        lst      = (pay_left == 0);
        ev       = event_word(mtep_pkg::KIND_PAYLOAD, b, '0, vlq_acc, lst, tv, tempo);
        if (lst) phase = is_eot ? STOPPED : WAIT_DELTA;
        return 1'b1;
      end
      default: return 1'b0;   // stopped after end of track
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Random track builder
  // -------------------------------------------------------------------------
  int unsigned n_counted = 0;   // bytes that are not plain discards
  logic [7:0]  gen_run = '0;    // builder's idea of running status
  bit          resync = 1'b0;   // next byte starts a new track

  function automatic void put_byte(input logic [7:0] b, input bit counts);
    track_byte_t tb_byte;
    tb_byte.ts       = resync;
    tb_byte.data     = b;
    tb_byte.fixed_ev = 1'b0;
    tb_byte.ev       = '0;
    if (resync) gen_run = '0;
    resync = 1'b0;
    track_bytes.push_back(tb_byte);
    if (counts) n_counted++;
  endfunction

  // pad adds leading 0x80 groups, still a legal encoding
  function automatic void put_vlq(input logic [27:0] v, input int unsigned pad);
    int unsigned n;
    int          i;
    logic [27:0] grp;
    n = 1;
    while (n < mtep_pkg::MAX_VLQ_BYTES && (v >> (7 * n)) != 0) n++;
    n = n + pad;
    if (n > mtep_pkg::MAX_VLQ_BYTES) n = mtep_pkg::MAX_VLQ_BYTES;
    for (i = n - 1; i >= 0; i--) begin
      grp = (v >> (7 * i)) & 28'h7F;
      put_byte({(i != 0), grp[6:0]}, 1'b1);
    end
  endfunction

  function automatic logic [7:0] any_data();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic int unsigned pad_bytes();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic void put_payload(input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) put_byte(8'($urandom_range(0, 255)), 1'b1);
  endfunction

  // One event: delta time then one message. Mostly well formed; a few
  // noise bytes and stray track starts, each followed by a new track.
  function automatic void build_event();
    int unsigned first;
    int unsigned pick;
    int unsigned len;
    int unsigned i;
    logic [7:0]  st;
    logic [7:0]  ty;
    first = track_bytes.size();
    pick  = $urandom_range(0, 99);
    if (pick < 75) begin
      put_vlq(28'($urandom_range(0, 127)), pad_bytes());
    end else if (pick < 93) begin
      put_vlq(28'($urandom), $urandom_range(0, 1));
    end else begin
      // every byte flagged as continued: cut off at the byte limit
      for (i = 0; i < mtep_pkg::MAX_VLQ_BYTES; i++)
        put_byte(8'h80 | 8'($urandom_range(0, 127)), 1'b1);
    end

    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      st = 8'($urandom_range(8'h80, 8'hEF));
      gen_run = st;
      put_byte(st, 1'b1);
      put_byte(any_data(), 1'b1);
      if (has_two_data(st)) put_byte(any_data(), 1'b1);
    end else if (pick < 60) begin
      // running status: first data byte must look like data
      put_byte(8'($urandom_range(0, 127)), 1'b1);
      if (gen_run != 0 && has_two_data(gen_run)) put_byte(any_data(), 1'b1);
    end else if (pick < 68) begin
      do st = 8'($urandom_range(8'hF1, 8'hFE)); while (st == mtep_pkg::ST_SYSEX_ESC);
      put_byte(st, 1'b1);
      put_byte(any_data(), 1'b1);
    end else if (pick < 76) begin
      put_byte($urandom_range(0, 1) ? mtep_pkg::ST_SYSEX : mtep_pkg::ST_SYSEX_ESC, 1'b1);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      put_vlq(28'(len), pad_bytes());
      put_payload(len);
    end else if (pick < 90) begin
      put_byte(mtep_pkg::ST_META, 1'b1);
      case ($urandom_range(0, 4))
        0, 1:    ty = mtep_pkg::META_TEMPO;
        2:       ty = 8'h01;
        default: do ty = 8'($urandom_range(0, 255)); while (ty == mtep_pkg::META_EOT);
      endcase
      put_byte(ty, 1'b1);
      if (ty == mtep_pkg::META_TEMPO)
        len = ($urandom_range(0, 9) < 7) ? 3 : $urandom_range(0, 6);
      else
        len = $urandom_range(0, 8);
      put_vlq(28'(len), pad_bytes());
      put_payload(len);
    end else if (pick < 96) begin
      put_byte(mtep_pkg::ST_META, 1'b1);
      put_byte(mtep_pkg::META_EOT, 1'b1);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
      put_vlq(28'(len), 0);
      put_payload(len);
      // discarded until the next track start
      for (i = $urandom_range(0, 3); i > 0; i--) put_byte(8'($urandom_range(0, 255)), 1'b0);
      resync = 1'b1;
    end else begin
      for (i = $urandom_range(1, 3); i > 0; i--) put_byte(8'($urandom_range(0, 255)), 1'b1);
      resync = 1'b1;
    end

    // rare track start in the middle of an event
    if ($urandom_range(0, 49) == 0) begin
      track_bytes[$urandom_range(first, track_bytes.size() - 1)].ts = 1'b1;
      resync = 1'b1;
    end
  endfunction

  // -------------------------------------------------------------------------
  // Sender: reset, then push every byte; the model runs on each accepted word
  // -------------------------------------------------------------------------
  initial begin : sender
    int unsigned       k;
    int unsigned       hold_points[$];
    bit                hit;
    mtep_pkg::result_t ev;
    track_byte_t       cur;

    clear_parser();
    foreach (DIRECTED[i]) track_bytes.push_back(DIRECTED[i]);
    resync = 1'b1;
    while (n_counted < TARGET_BYTES) build_event();
    // let the block drain completely after the table and once mid-run
    hold_points.push_back($size(DIRECTED));
    hold_points.push_back(track_bytes.size() / 2);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    k = 0;
    while (k < track_bytes.size()) begin
      quiet = (k >= QUIET_LO) && (k < QUIET_HI);
      if (hold_points.size() != 0 && k == hold_points[0]) begin
        void'(hold_points.pop_front());
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_events.size() != 0);
      end else if (!quiet && $urandom_range(0, 99) < 28) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end else begin
        cur = track_bytes[k];
        in_valid    <= 1'b1;
        track_start <= cur.ts;
        byte_in     <= cur.data;
        // inputs settle by the falling edge; the word goes at the next rise
        @(negedge clk);
        while (in_stall) @(negedge clk);
        hit = parse_byte(cur.ts, cur.data, ev);
        if (cur.fixed_ev) pending_events.push_back(cur.ev);
        else if (hit)     pending_events.push_back(ev);
        @(posedge clk);
        k++;
      end
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (pending_events.size() != 0) @(posedge clk);
    // catch any stray word still in the pipe
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("SUCCESS");
    else               $display("FAILURE");
    $finish;
  end

  // Receiver back-pressure, off during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 28);
  end

  task automatic check_field(input string name, input logic [27:0] want,
                             input logic [27:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  // Output words are compared at the falling edge before the rise that
  // takes them, when every signal is stable.
  always @(negedge clk) begin : event_check
    mtep_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("event word with nothing pending: kind %0h status %0h", kind, status);
        n_errors++;
      end else begin
        want = pending_events.pop_front();
        check_field("kind", want.kind, kind);
        check_field("delta_ticks", want.delta_ticks, delta_ticks);
        check_field("status", want.status, status);
        check_field("data1", want.data1, data1);
        check_field("data2", want.data2, data2);
        check_field("payload_length", want.payload_length, payload_length);
        check_field("last_payload", want.last_payload, last_payload);
        check_field("tempo_valid", want.tempo_valid, tempo_valid);
        check_field("tempo_us", want.tempo_us, tempo_us);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule
